// File: src/tksd_pkg.sv
package tksd_pkg;

	// parse phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_ESC   = 3'd1;
	localparam logic [2:0] PH_CSI   = 3'd2;
	localparam logic [2:0] PH_DIGIT = 3'd3;
	localparam logic [2:0] PH_SEMI  = 3'd4;
	localparam logic [2:0] PH_MOD   = 3'd5;
	localparam logic [2:0] PH_SS3   = 3'd6;

	// key kinds
	localparam logic [3:0] K_CHAR  = 4'd0;
	localparam logic [3:0] K_TAB   = 4'd1;
	localparam logic [3:0] K_HOME  = 4'd2;
	localparam logic [3:0] K_END   = 4'd3;
	localparam logic [3:0] K_DEL   = 4'd4;
	localparam logic [3:0] K_PGUP  = 4'd5;
	localparam logic [3:0] K_PGDN  = 4'd6;
	localparam logic [3:0] K_UP    = 4'd7;
	localparam logic [3:0] K_DOWN  = 4'd8;
	localparam logic [3:0] K_RIGHT = 4'd9;
	localparam logic [3:0] K_LEFT  = 4'd10;

	// byte constants
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_US    = 8'h1F;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;

	localparam logic [4:0] ENTER_RESET = 5'd13;

	typedef struct packed {
		logic [3:0] key_kind;
		logic       ctrl_mod;
		logic       meta_mod;
		logic [7:0] char_value;
	} key_res_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] held_digit;
		logic       mod_is_five;
	} parse_st_t;

	// plain byte mapping, control bytes other than the enter code get the control modifier
	function automatic key_res_t map_byte(input logic [7:0] c, input logic [4:0] enter);
		key_res_t r;
		r = '0;
		r.key_kind = K_CHAR;
		if (c <= CH_US && c[4:0] != enter) begin
			r.ctrl_mod = 1'b1;
			if (c == CH_US) begin
				r.char_value = CH_SLASH;
			end else if (c == CH_NUL) begin
				r.char_value = CH_SPACE;
			end else begin
				r.char_value = c + CH_AT;
			end
		end else begin
			r.char_value = c;
		end
		return r;
	endfunction

	function automatic logic [3:0] arrow_kind(input logic [7:0] c);
		case (c)
			8'h41:   return K_UP;
			8'h42:   return K_DOWN;
			8'h43:   return K_RIGHT;
			8'h44:   return K_LEFT;
			default: return K_CHAR;
		endcase
	endfunction

	function automatic logic [3:0] tilde_kind(input logic [7:0] d);
		case (d)
			8'h31, 8'h37: return K_HOME;
			8'h33:        return K_DEL;
			8'h34, 8'h38: return K_END;
			8'h35:        return K_PGUP;
			8'h36:        return K_PGDN;
			default:      return K_CHAR;
		endcase
	endfunction

endpackage

// File: src/tksd_ifs.sv
interface tksd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] byte_value;

	modport source (output valid, output func, output byte_value, input ready);
	modport sink   (input valid, input func, input byte_value, output ready);
endinterface

interface tksd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_kind;
	logic       ctrl_mod;
	logic       meta_mod;
	logic [7:0] char_value;

	modport source (output valid, output key_kind, output ctrl_mod, output meta_mod,
		output char_value, input ready);
	modport sink   (input valid, input key_kind, input ctrl_mod, input meta_mod,
		input char_value, output ready);
endinterface

interface tksd_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/tksd_decode.sv
module tksd_decode (
	input  tksd_pkg::parse_st_t cur,
	input  logic                func,
	input  logic [7:0]          byte_value,
	input  logic [4:0]          enter_code,
	output tksd_pkg::parse_st_t nxt,
	output logic                emit,
	output tksd_pkg::key_res_t  res
);
	import tksd_pkg::*;

	logic       broken;
	logic [3:0] k;

	// one state transition per item
	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		broken = 1'b0;
		res    = '0;
		k      = arrow_kind(byte_value);
		if (cur.phase == PH_IDLE || cur.phase > PH_SS3) begin
			nxt.phase = PH_IDLE;
			if (!func) begin
				if (byte_value == CH_TAB) begin
					emit         = 1'b1;
					res.key_kind = K_TAB;
				end else if (byte_value == CH_ESC) begin
					nxt.phase = PH_ESC;
				end else begin
					emit = 1'b1;
					res  = map_byte(byte_value, enter_code);
				end
			end
		end else if (func) begin
			// timeout inside a sequence gives plain escape
			emit           = 1'b1;
			res.char_value = CH_ESC;
		end else begin
			case (cur.phase)
				PH_ESC: begin
					if (byte_value == CH_LBRK) begin
						nxt.phase = PH_CSI;
					end else if (byte_value == CH_O) begin
						nxt.phase = PH_SS3;
					end else if (byte_value inside {[CH_SPACE:CH_TILDE]}) begin
						emit           = 1'b1;
						res.meta_mod   = 1'b1;
						res.char_value = byte_value;
					end else begin
						broken = 1'b1;
					end
				end
				PH_CSI: begin
					if (byte_value inside {[CH_ZERO:CH_NINE]}) begin
						nxt.held_digit = byte_value;
						nxt.phase      = PH_DIGIT;
					end else if (k != K_CHAR) begin
						emit         = 1'b1;
						res.key_kind = k;
					end else begin
						broken = 1'b1;
					end
				end
				PH_DIGIT: begin
					if (byte_value == CH_TILDE && tilde_kind(cur.held_digit) != K_CHAR) begin
						emit         = 1'b1;
						res.key_kind = tilde_kind(cur.held_digit);
					end else if (byte_value == CH_SEMI) begin
						nxt.phase = PH_SEMI;
					end else begin
						broken = 1'b1;
					end
				end
				PH_SEMI: begin
					nxt.mod_is_five = (byte_value == CH_FIVE);
					nxt.phase       = PH_MOD;
				end
				PH_MOD: begin
					if (cur.mod_is_five && k != K_CHAR) begin
						emit         = 1'b1;
						res.key_kind = k;
						res.ctrl_mod = 1'b1;
					end else begin
						broken = 1'b1;
					end
				end
				default: begin
					// single shift three: home, end or plain escape
					emit = 1'b1;
					if (byte_value == CH_H) begin
						res.key_kind = K_HOME;
					end else if (byte_value == CH_F) begin
						res.key_kind = K_END;
					end else begin
						res.char_value = CH_ESC;
					end
				end
			endcase
			// broken sequence decodes the escape itself
			if (broken) begin
				emit = 1'b1;
				res  = map_byte(CH_ESC, enter_code);
			end
		end
		if (emit) begin
			nxt.phase = PH_IDLE;
		end
	end

endmodule

// File: src/terminal_key_sequence_decoder_top.sv
// Terminal key sequence decoder.
// key_in carries one item per transfer: func low with a received byte in
// byte_value, or func high for a read timeout with no byte. key_out carries
// decoded key events (key_kind, ctrl_mod, meta_mod, char_value). An item
// gives zero or one event; bytes inside an escape sequence give none until
// the sequence completes, breaks or times out.
// cfg writes the enter_code register (5 bits, 13 after reset); write it only
// while no item is in flight.
// Timing: an item is registered in the input register on its input transfer,
// then decoded into the result register, whose event stays valid on key_out
// until it transfers. Throughput: one item per cycle while key_out does not
// stall, set by the single parse-state register that each item updates.
// Output stall: the result register holds its event while key_out.ready is
// low, the input register can still take one more item, then key_in.ready
// drops until the result is taken.
// Reset: arst_n clears the parse state to idle, empties both registers and
// loads enter_code with 13.
module terminal_key_sequence_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	tksd_in_if.sink   key_in,
	tksd_out_if.source key_out,
	tksd_cfg_if.sink  cfg
);
	import tksd_pkg::*;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	parse_st_t  st_q;
	parse_st_t  st_nxt;
	logic       emit;
	key_res_t   res;
	key_res_t   res_q;
	logic       res_valid_q;
	logic [4:0] enter_q;
	logic       advance;

	// stage two can take a new result when empty or draining
	assign advance      = !res_valid_q || key_out.ready;
	assign key_in.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= ENTER_RESET;
		end else if (cfg.valid) begin
			enter_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			func_s1 <= key_in.func;
			byte_s1 <= key_in.byte_value;
		end
	end

	tksd_decode u_decode (
		.cur        (st_q),
		.func       (func_s1),
		.byte_value (byte_s1),
		.enter_code (enter_q),
		.nxt        (st_nxt),
		.emit       (emit),
		.res        (res)
	);

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '{phase: PH_IDLE, held_digit: 8'd0, mod_is_five: 1'b0};
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			res_q <= res;
		end
	end

	assign key_out.valid      = res_valid_q;
	assign key_out.key_kind   = res_q.key_kind;
	assign key_out.ctrl_mod   = res_q.ctrl_mod;
	assign key_out.meta_mod   = res_q.meta_mod;
	assign key_out.char_value = res_q.char_value;

	// parse state never takes an unused code
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= PH_SS3)
		else $error("parse phase out of range");

	// leaving idle only by an escape byte
	a_idle_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && st_q.phase == PH_IDLE)
		|=> (st_q.phase == PH_IDLE || st_q.phase == PH_ESC))
		else $error("idle left without escape");

	// named keys carry no character
	a_kind_char: assert property (@(posedge clk) disable iff (!arst_n)
		(key_out.valid && key_out.key_kind != K_CHAR) |-> (key_out.char_value == 8'd0))
		else $error("named key with character");

	// control on a named key only for arrows, never with meta
	a_mods: assert property (@(posedge clk) disable iff (!arst_n)
		key_out.valid |-> (!(key_out.ctrl_mod && key_out.meta_mod)
		&& (!key_out.ctrl_mod || key_out.key_kind == K_CHAR || key_out.key_kind >= K_UP)
		&& key_out.key_kind <= K_LEFT))
		else $error("bad modifier combination");

	// an event is emitted only in the cycle after a processed item
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("event without item");

endmodule

// File: dv/tksd_tb_pkg.sv
package tksd_tb_pkg;

	import tksd_pkg::*;

	// final bytes of the arrow sequences
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;

	class key_decode_scoreboard;
		logic [4:0] enter_code;
		logic [2:0] phase;
		logic [7:0] digit;
		bit         mod_five;
		key_res_t   expected_keys[$];
		int unsigned mismatches;

		function new();
			enter_code = ENTER_RESET;
			phase = PH_IDLE;
			digit = '0;
			mod_five = 1'b0;
			mismatches = 0;
		endfunction

		function void set_enter(input logic [4:0] v);
			enter_code = v;
		endfunction

		function int outstanding();
			return expected_keys.size();
		endfunction

		// byte outside a sequence; non-enter ctrl bytes: ctrl, 1-30 +64
		function key_res_t plain_key(input logic [7:0] c);
			key_res_t r;
			r = '0;
			r.key_kind = K_CHAR;
			if (c <= CH_US && c[4:0] != enter_code) begin
				r.ctrl_mod = 1'b1;
				if (c == CH_US) begin
					r.char_value = CH_SLASH;
				end else if (c == CH_NUL) begin
					r.char_value = CH_SPACE;
				end else begin
					r.char_value = c + CH_AT;
				end
			end else begin
				r.char_value = c;
			end
			return r;
		endfunction

		function logic [3:0] arrow_of(input logic [7:0] c);
			case (c)
				CH_A:    return K_UP;
				CH_B:    return K_DOWN;
				CH_C:    return K_RIGHT;
				CH_D:    return K_LEFT;
				default: return K_CHAR;
			endcase
		endfunction

		function logic [3:0] tilde_of(input logic [7:0] d);
			case (d - CH_ZERO)
				8'd1, 8'd7: return K_HOME;
				8'd3:       return K_DEL;
				8'd4, 8'd8: return K_END;
				8'd5:       return K_PGUP;
				8'd6:       return K_PGDN;
				default:    return K_CHAR;
			endcase
		endfunction

		// one parser step, returns 1 when a key event comes out
		function bit decode_item(input bit timeout, input logic [7:0] c, output key_res_t r);
			logic [3:0] k;
			r = '0;
			r.key_kind = K_CHAR;
			if (phase == PH_IDLE || phase > PH_SS3) begin
				phase = PH_IDLE;
				if (timeout) return 1'b0;
				if (c == CH_TAB) begin
					r.key_kind = K_TAB;
					return 1'b1;
				end
				if (c == CH_ESC) begin
					phase = PH_ESC;
					return 1'b0;
				end
				r = plain_key(c);
				return 1'b1;
			end
			// timeout inside a sequence gives a bare escape
			if (timeout) begin
				phase = PH_IDLE;
				r.char_value = CH_ESC;
				return 1'b1;
			end
			case (phase)
				PH_ESC: begin
					if (c == CH_LBRK) begin
						phase = PH_CSI;
						return 1'b0;
					end
					if (c == CH_O) begin
						phase = PH_SS3;
						return 1'b0;
					end
					if (c >= CH_SPACE && c <= CH_TILDE) begin
						phase = PH_IDLE;
						r.meta_mod = 1'b1;
						r.char_value = c;
						return 1'b1;
					end
				end
				PH_CSI: begin
					if (c >= CH_ZERO && c <= CH_NINE) begin
						digit = c;
						phase = PH_DIGIT;
						return 1'b0;
					end
					k = arrow_of(c);
					if (k != K_CHAR) begin
						phase = PH_IDLE;
						r.key_kind = k;
						return 1'b1;
					end
				end
				PH_DIGIT: begin
					if (c == CH_TILDE) begin
						k = tilde_of(digit);
						if (k != K_CHAR) begin
							phase = PH_IDLE;
							r.key_kind = k;
							return 1'b1;
						end
					end else if (c == CH_SEMI) begin
						phase = PH_SEMI;
						return 1'b0;
					end
				end
				PH_SEMI: begin
					mod_five = (c == CH_FIVE);
					phase = PH_MOD;
					return 1'b0;
				end
				PH_MOD: begin
					k = arrow_of(c);
					if (mod_five && k != K_CHAR) begin
						phase = PH_IDLE;
						r.key_kind = k;
						r.ctrl_mod = 1'b1;
						return 1'b1;
					end
				end
				default: begin
					phase = PH_IDLE;
					if (c == CH_H) begin
						r.key_kind = K_HOME;
					end else if (c == CH_F) begin
						r.key_kind = K_END;
					end else begin
						r.char_value = CH_ESC;
					end
					return 1'b1;
				end
			endcase
			// broken sequence, the escape itself is decoded as a byte
			phase = PH_IDLE;
			r = plain_key(CH_ESC);
			return 1'b1;
		endfunction

		function void note_item(input bit timeout, input logic [7:0] c);
			key_res_t r;
			if (decode_item(timeout, c, r)) expected_keys.push_back(r);
		endfunction

		task report_mismatch(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_key(input key_res_t got);
			key_res_t want;
			if (expected_keys.size() == 0) begin
				report_mismatch($sformatf("unexpected key event %h", got));
				return;
			end
			want = expected_keys.pop_front();
			if (got.key_kind != want.key_kind)
				report_mismatch($sformatf("key_kind %0d, want %0d", got.key_kind, want.key_kind));
			if (got.ctrl_mod != want.ctrl_mod)
				report_mismatch($sformatf("ctrl_mod %0d, want %0d", got.ctrl_mod, want.ctrl_mod));
			if (got.meta_mod != want.meta_mod)
				report_mismatch($sformatf("meta_mod %0d, want %0d", got.meta_mod, want.meta_mod));
			if (got.char_value != want.char_value)
				report_mismatch($sformatf("char_value %h, want %h",
					got.char_value, want.char_value));
		endtask
	endclass

endpackage

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tksd_pkg::*;
	import tksd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES = 200;

	logic clk;
	logic arst_n;

	tksd_in_if  key_in();
	tksd_out_if key_out();
	tksd_cfg_if cfg();

	terminal_key_sequence_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_in),
		.key_out (key_out),
		.cfg     (cfg)
	);

	key_decode_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int hold_request;
	int bytes_sent;
	int cycle_count;

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** terminal_key_sequence_decoder_top: FAILED **");
			$finish;
		end
	end

	// key event sink with random stalls and a long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		if (arst_n) begin
			if (key_out.valid && key_out.ready)
				sb.check_key({key_out.key_kind, key_out.ctrl_mod, key_out.meta_mod,
					key_out.char_value});
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				key_out.ready <= 1'b0;
				hold_left--;
			end else begin
				key_out.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic push_item(input bit f, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			key_in.valid <= 1'b0;
			@(posedge clk);
		end
		key_in.valid <= 1'b1;
		key_in.func <= f;
		key_in.byte_value <= b;
		@(posedge clk);
		while (!key_in.ready) @(posedge clk);
		sb.note_item(f, b);
		if (!f) bytes_sent++;
	endtask

	task automatic push_timeout();
		push_item(1'b1, 8'($urandom));
	endtask

	// stop sending and wait for every pending key event
	task automatic drain();
		key_in.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enter(input logic [4:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		sb.set_enter(v);
	endtask

	// mostly well-formed sequences with random content, some corrupted, some noise
	task automatic push_sequence();
		logic [7:0] seq[$];
		int pick;
		int i;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			push_item($urandom_range(0, 3) == 0, 8'($urandom));
			return;
		end
		case ($urandom_range(0, 6))
			0: begin
				seq.push_back(CH_ESC);
				seq.push_back(CH_LBRK);
				seq.push_back(CH_A + 8'($urandom_range(0, 3)));
			end
			1: begin
				seq.push_back(CH_ESC);
				seq.push_back(CH_LBRK);
				seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				seq.push_back(CH_TILDE);
			end
			2: begin
				seq.push_back(CH_ESC);
				seq.push_back(CH_LBRK);
				seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				seq.push_back(CH_SEMI);
				seq.push_back(($urandom_range(0, 3) != 0) ? CH_FIVE : 8'($urandom));
				seq.push_back(($urandom_range(0, 4) != 0) ?
					CH_A + 8'($urandom_range(0, 3)) : 8'($urandom));
			end
			3: begin
				seq.push_back(CH_ESC);
				seq.push_back(CH_O);
				pick = $urandom_range(0, 9);
				seq.push_back((pick < 4) ? CH_H : (pick < 8) ? CH_F : 8'($urandom));
			end
			4: begin
				seq.push_back(CH_ESC);
				seq.push_back(8'($urandom));
			end
			5: begin
				pick = $urandom_range(0, 3);
				seq.push_back((pick == 0) ? CH_TAB :
					(pick == 1) ? 8'($urandom_range(0, 31)) : 8'($urandom));
			end
			default: begin
				// prefix cut short by a timeout
				seq.push_back(CH_ESC);
				pick = $urandom_range(0, 3);
				if (pick > 0) seq.push_back(($urandom_range(0, 1) != 0) ? CH_LBRK : CH_O);
				if (pick > 1) seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if (pick > 2) seq.push_back(CH_SEMI);
				push_item(1'b0, seq[0]);
				for (i = 1; i < seq.size(); i++) push_item(1'b0, seq[i]);
				push_timeout();
				return;
			end
		endcase
		for (i = 0; i < seq.size(); i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) push_timeout();
			else if (pick < 8) push_item(1'b0, 8'($urandom));
			else push_item(1'b0, seq[i]);
		end
	endtask

	initial begin
		logic [4:0] enters[4];
		int send_pcts[4];
		int stall_pcts[4];
		bit hold_done;
		int i;
		enters = '{5'd0, 5'd31, 5'd9, 5'd27};
		send_pcts = '{0, 67, 0, 37};
		stall_pcts = '{0, 0, 67, 37};
		hold_done = 1'b0;
		arst_n = 1'b0;
		key_in.valid = 1'b0;
		key_in.func = 1'b0;
		key_in.byte_value = '0;
		key_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		bytes_sent = 0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: control byte extremes, tab, enter, idle timeout
		push_item(1'b0, CH_NUL);
		push_item(1'b0, CH_US);
		push_item(1'b0, 8'hFF);
		push_item(1'b0, CH_TAB);
		push_item(1'b0, {3'b000, ENTER_RESET});
		push_timeout();
		// arrow, tilde key, ctrl arrow, ss3 home
		push_item(1'b0, CH_ESC);
		push_item(1'b0, CH_LBRK);
		push_item(1'b0, CH_A);
		push_item(1'b0, CH_ESC);
		push_item(1'b0, CH_LBRK);
		push_item(1'b0, CH_FIVE);
		push_item(1'b0, CH_TILDE);
		push_item(1'b0, CH_ESC);
		push_item(1'b0, CH_LBRK);
		push_item(1'b0, CH_ZERO + 8'd1);
		push_item(1'b0, CH_SEMI);
		push_item(1'b0, CH_FIVE);
		push_item(1'b0, CH_D);
		push_item(1'b0, CH_ESC);
		push_item(1'b0, CH_O);
		push_item(1'b0, CH_H);
		// escape then timeout, meta char, escape plus control byte
		push_item(1'b0, CH_ESC);
		push_timeout();
		push_item(1'b0, CH_ESC);
		push_item(1'b0, 8'h61);
		push_item(1'b0, CH_ESC);
		push_item(1'b0, 8'h01);

		// random phases, each with its own enter code and idling mix
		for (int p = 0; p < 4; p++) begin
			write_enter(enters[p]);
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES) begin
				push_sequence();
				if (p == 0 && !hold_done && bytes_sent >= PHASE_BYTES / 2) begin
					// long sink hold-off while bytes keep coming, then full drain
					hold_done = 1'b1;
					hold_request = 400;
					for (i = 0; i < 40; i++)
						push_item(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
					drain();
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("** terminal_key_sequence_decoder_top: PASSED **");
		end else begin
			$display("** terminal_key_sequence_decoder_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
src/tksd_pkg.sv
src/tksd_ifs.sv
src/tksd_decode.sv
src/terminal_key_sequence_decoder_top.sv
dv/tksd_tb_pkg.sv
dv/tb_top.sv
